### design/grid_cell_neighbor_index_assert.svh
// Assertion helpers shared by the fifo, front and back design files.
`ifndef GRID_CELL_NEIGHBOR_INDEX_ASSERT_SVH
`define GRID_CELL_NEIGHBOR_INDEX_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define GCNI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define GCNI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GCNI_ASSERT_NOW(lbl, ante, cons, msg)
`define GCNI_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### design/gcni_pkg.sv
package gcni_pkg;

  localparam int IDX_W  = 20;
  localparam int CFG_W  = 11;
  localparam int POS_W  = 10;
  localparam int CNT_W  = 3;
  localparam int ST_W   = 2;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam int NB_W   = 4;

  localparam int CFG_MAX     = (1 << CFG_W) - 1;
  localparam int MAX_DIM_DEF = 1024;
  localparam int QDEPTH      = 2;

  typedef enum logic [ST_W-1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_OOR  = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    REG_COLS = 1'b0,
    REG_ROWS = 1'b1
  } reg_idx_t;

  // one divided query on its way from front to back
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [CFG_W-1:0] col;
    logic [CFG_W-1:0] row;
    logic             oor;
  } gcni_job_t;

  // zero reads as one, large values clip to sat
  function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] v,
                                               input logic [CFG_W-1:0] sat);
    logic [CFG_W-1:0] res;
    if (v == '0) begin
      res = CFG_W'(1);
    end else if (v > sat) begin
      res = sat;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

### design/gcni_in_if.sv
interface gcni_in_if import gcni_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] cell_index;

  modport source (output valid, output cell_index, input ready);
  modport sink (input valid, input cell_index, output ready);
endinterface

### design/gcni_out_if.sv
interface gcni_out_if import gcni_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] neighbor_index;
  logic [POS_W-1:0] cell_col;
  logic [POS_W-1:0] cell_row;
  logic [CNT_W-1:0] neighbor_count;
  logic [ST_W-1:0]  status;
  logic             last;

  modport source (output valid, output neighbor_index, output cell_col,
                  output cell_row, output neighbor_count, output status,
                  output last, input ready);
  modport sink (input valid, input neighbor_index, input cell_col,
                input cell_row, input neighbor_count, input status,
                input last, output ready);
endinterface

### design/gcni_fifo.sv
`include "grid_cell_neighbor_index_assert.svh"

module gcni_fifo import gcni_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  gcni_job_t din,
  output logic      full,
  input  logic      pop,
  output gcni_job_t dout,
  output logic      valid
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  gcni_job_t         mem_r [QDEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     count_r, count_nxt;

  assign full  = (count_r == CW'(QDEPTH));
  assign valid = (count_r != '0);
  assign dout  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  `GCNI_ASSERT_NOW(a_fifo_no_overflow, push, !full || pop, "queue overflow")
  `GCNI_ASSERT_NOW(a_fifo_no_underflow, pop, valid, "queue underflow")

endmodule

### design/gcni_front.sv
`include "grid_cell_neighbor_index_assert.svh"

module gcni_front import gcni_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  gcni_in_if.sink          in_ch,
  input  logic [CFG_W-1:0] eff_cols,
  input  logic [CFG_W-1:0] eff_rows,
  output gcni_job_t        job,
  output logic             job_push,
  input  logic             job_full
);

  // quotient (row) stays below MAX_DIM for in-range queries; 3 bits per cycle
  localparam int QW     = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
  localparam int QSTEPS = (QW + 2) / 3;
  localparam int QB     = 3 * QSTEPS;
  localparam int DVW    = CFG_W + QB - 1;
  localparam int CW     = (IDX_W > DVW) ? IDX_W : DVW;
  localparam int SCW    = (QSTEPS > 1) ? $clog2(QSTEPS) : 1;

  logic             busy_r, busy_nxt;
  logic [SCW-1:0]   step_r, step_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             oor_r, oor_nxt;
  logic [IDX_W-1:0] rem_r, rem_nxt;
  logic [QB-1:0]    quo_r, quo_nxt;
  logic [DVW-1:0]   div_r, div_nxt;

  logic [IDX_W-1:0]   rem_step;
  logic [QB-1:0]      quo_step;
  logic [2*CFG_W-1:0] cells;
  logic               last_step;
  logic               accept;

  assign last_step   = (step_r == SCW'(QSTEPS - 1));
  assign job_push    = busy_r && last_step && !job_full;
  assign in_ch.ready = !busy_r || job_push;
  assign accept      = in_ch.valid && in_ch.ready;
  assign cells       = (2*CFG_W)'(eff_cols) * (2*CFG_W)'(eff_rows);

  // three restoring steps of the shared divider
  always_comb begin
    logic [IDX_W-1:0] r;
    logic [QB-1:0]    q;
    logic [DVW-1:0]   d;
    r = rem_r;
    q = quo_r;
    for (int k = 0; k < 3; k++) begin
      d = div_r >> k;
      if (CW'(r) >= CW'(d)) begin
        r = r - IDX_W'(d);
        q = {q[QB-2:0], 1'b1};
      end else begin
        q = {q[QB-2:0], 1'b0};
      end
    end
    rem_step = r;
    quo_step = q;
  end

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    idx_nxt  = idx_r;
    oor_nxt  = oor_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    if (accept) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      idx_nxt  = in_ch.cell_index;
      oor_nxt  = ((2*CFG_W)'(in_ch.cell_index) >= cells);
      rem_nxt  = in_ch.cell_index;
      quo_nxt  = '0;
      div_nxt  = DVW'(eff_cols) << (QB - 1);
    end else if (job_push) begin
      busy_nxt = 1'b0;
    end else if (busy_r && !last_step) begin
      step_nxt = step_r + SCW'(1);
      rem_nxt  = rem_step;
      quo_nxt  = quo_step;
      div_nxt  = div_r >> 3;
    end
  end

  assign job.idx = idx_r;
  assign job.col = CFG_W'(rem_step);
  assign job.row = CFG_W'(quo_step);
  assign job.oor = oor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    oor_r <= oor_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  `GCNI_ASSERT_NEXT(a_front_accept_busy, accept, busy_r && step_r == '0,
                    "divider not started after accept")

endmodule

### design/gcni_back.sv
`include "grid_cell_neighbor_index_assert.svh"

module gcni_back import gcni_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CFG_W-1:0] eff_cols,
  input  logic [CFG_W-1:0] eff_rows,
  input  gcni_job_t        job,
  input  logic             job_valid,
  output logic             job_pop,
  gcni_out_if.source       out_ch
);

  // neighbor mask bits in ascending index order
  localparam int NB_UP    = 0;
  localparam int NB_LEFT  = 1;
  localparam int NB_RIGHT = 2;
  localparam int NB_DOWN  = 3;

  logic             act_r, act_nxt;
  logic [IDX_W-1:0] cur_idx_r, cur_idx_nxt;
  logic [CFG_W-1:0] cur_col_r, cur_col_nxt;
  logic [CFG_W-1:0] cur_row_r, cur_row_nxt;
  logic [NB_W-1:0]  cur_mask_r, cur_mask_nxt;
  logic [CNT_W-1:0] cur_cnt_r, cur_cnt_nxt;
  logic             cur_oor_r, cur_oor_nxt;

  logic             ov_r, ov_nxt;
  logic [IDX_W-1:0] o_nb_r, o_nb_nxt;
  logic [POS_W-1:0] o_col_r, o_col_nxt;
  logic [POS_W-1:0] o_row_r, o_row_nxt;
  logic [CNT_W-1:0] o_cnt_r, o_cnt_nxt;
  status_t          o_st_r, o_st_nxt;
  logic             o_last_r, o_last_nxt;

  logic [NB_W-1:0]  load_mask;
  logic [NB_W-1:0]  mask_rest;
  logic [IDX_W-1:0] nb_sel;
  logic             out_take;
  logic             fire;
  logic             emit_last;

  always_comb begin
    load_mask = '0;
    if (!job.oor) begin
      load_mask[NB_UP]    = (job.row != '0);
      load_mask[NB_LEFT]  = (job.col != '0);
      load_mask[NB_RIGHT] = ({1'b0, job.col} + (CFG_W+1)'(1)) < {1'b0, eff_cols};
      load_mask[NB_DOWN]  = ({1'b0, job.row} + (CFG_W+1)'(1)) < {1'b0, eff_rows};
    end
  end

  assign mask_rest = cur_mask_r & (cur_mask_r - NB_W'(1));
  assign emit_last = (mask_rest == '0);
  assign out_take  = !ov_r || out_ch.ready;
  assign fire      = act_r && out_take;
  assign job_pop   = job_valid && (!act_r || (fire && emit_last));

  always_comb begin
    if (cur_mask_r[NB_UP]) begin
      nb_sel = cur_idx_r - IDX_W'(eff_cols);
    end else if (cur_mask_r[NB_LEFT]) begin
      nb_sel = cur_idx_r - IDX_W'(1);
    end else if (cur_mask_r[NB_RIGHT]) begin
      nb_sel = cur_idx_r + IDX_W'(1);
    end else begin
      nb_sel = cur_idx_r + IDX_W'(eff_cols);
    end
  end

  always_comb begin
    act_nxt      = act_r;
    cur_idx_nxt  = cur_idx_r;
    cur_col_nxt  = cur_col_r;
    cur_row_nxt  = cur_row_r;
    cur_mask_nxt = cur_mask_r;
    cur_cnt_nxt  = cur_cnt_r;
    cur_oor_nxt  = cur_oor_r;
    if (job_pop) begin
      act_nxt      = 1'b1;
      cur_idx_nxt  = job.idx;
      cur_col_nxt  = job.col;
      cur_row_nxt  = job.row;
      cur_mask_nxt = load_mask;
      cur_cnt_nxt  = CNT_W'(load_mask[NB_UP]) + CNT_W'(load_mask[NB_LEFT])
                   + CNT_W'(load_mask[NB_RIGHT]) + CNT_W'(load_mask[NB_DOWN]);
      cur_oor_nxt  = job.oor;
    end else if (fire && emit_last) begin
      act_nxt = 1'b0;
    end else if (fire) begin
      cur_mask_nxt = mask_rest;
    end
  end

  always_comb begin
    ov_nxt     = ov_r;
    o_nb_nxt   = o_nb_r;
    o_col_nxt  = o_col_r;
    o_row_nxt  = o_row_r;
    o_cnt_nxt  = o_cnt_r;
    o_st_nxt   = o_st_r;
    o_last_nxt = o_last_r;
    if (fire) begin
      ov_nxt     = 1'b1;
      o_last_nxt = emit_last;
      if (cur_oor_r) begin
        o_nb_nxt  = '0;
        o_col_nxt = '0;
        o_row_nxt = '0;
        o_cnt_nxt = '0;
        o_st_nxt  = ST_OOR;
      end else if (cur_mask_r == '0) begin
        o_nb_nxt  = '0;
        o_col_nxt = POS_W'(cur_col_r);
        o_row_nxt = POS_W'(cur_row_r);
        o_cnt_nxt = '0;
        o_st_nxt  = ST_NONE;
      end else begin
        o_nb_nxt  = nb_sel;
        o_col_nxt = POS_W'(cur_col_r);
        o_row_nxt = POS_W'(cur_row_r);
        o_cnt_nxt = cur_cnt_r;
        o_st_nxt  = ST_OK;
      end
    end else if (out_ch.ready) begin
      ov_nxt = 1'b0;
    end
  end

  assign out_ch.valid          = ov_r;
  assign out_ch.neighbor_index = o_nb_r;
  assign out_ch.cell_col       = o_col_r;
  assign out_ch.cell_row       = o_row_r;
  assign out_ch.neighbor_count = o_cnt_r;
  assign out_ch.status         = o_st_r;
  assign out_ch.last           = o_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      act_r <= act_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_idx_r  <= cur_idx_nxt;
    cur_col_r  <= cur_col_nxt;
    cur_row_r  <= cur_row_nxt;
    cur_mask_r <= cur_mask_nxt;
    cur_cnt_r  <= cur_cnt_nxt;
    cur_oor_r  <= cur_oor_nxt;
    o_nb_r     <= o_nb_nxt;
    o_col_r    <= o_col_nxt;
    o_row_r    <= o_row_nxt;
    o_cnt_r    <= o_cnt_nxt;
    o_st_r     <= o_st_nxt;
    o_last_r   <= o_last_nxt;
  end

  `GCNI_ASSERT_NOW(a_back_err_last, ov_r && o_st_r != ST_OK, o_last_r,
                   "error or no-neighbor result not marked last")
  `GCNI_ASSERT_NOW(a_back_cnt_range, ov_r && o_st_r == ST_OK,
                   o_cnt_r != '0 && o_cnt_r <= CNT_W'(NB_W),
                   "neighbor count out of range")
  `GCNI_ASSERT_NEXT(a_back_pop_loads, job_pop, act_r, "popped query not loaded")

endmodule

### design/grid_cell_neighbor_index.sv
// Four-neighbor index generator for a row-major grid.
// in_ch carries one query transaction (cell_index). out_ch returns one
// transaction per edge-adjacent cell inside the grid, in ascending index order
// (above, left, right, below); last marks the final one of a query. An index
// at or past columns*rows returns a single error transaction, a 1x1 grid a
// single no-neighbor transaction.
// Grid size sits in two APB registers: columns at 0x0, rows at 0x4 (0 counts as
// 1, values above MAX_DIM clip). Write them only while no query is in flight.
// The front splits the index into row and column with a shared restoring
// divider, 3 quotient bits per cycle. A 2-entry queue feeds the back, which
// emits one result per cycle through an output register while out_ch.ready
// is high. The front can accept a new query in the cycle it hands the previous
// one to the queue. A query passes the divider, the queue, the back's query
// register and the output register before its first result.
// Reset (rst_n low at a clock edge) empties the pipe and sets both dimensions
// to 1. A stalled receiver holds the output register; the queue then fills
// and in_ch.ready drops until results drain.
module grid_cell_neighbor_index import gcni_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  gcni_in_if.sink           in_ch,
  gcni_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  // clip value for the dimension registers
  localparam logic [CFG_W-1:0] DIM_SAT = CFG_W'((MAX_DIM > CFG_MAX) ? CFG_MAX : MAX_DIM);

  logic [CFG_W-1:0] cols_r, cols_nxt;
  logic [CFG_W-1:0] rows_r, rows_nxt;
  logic [CFG_W-1:0] eff_cols;
  logic [CFG_W-1:0] eff_rows;
  reg_idx_t         reg_sel;
  logic             cfg_wr;

  gcni_job_t        push_job;
  gcni_job_t        head_job;
  logic             job_push;
  logic             job_full;
  logic             job_pop;
  logic             job_valid;

  // register file: byte address 4*i selects register i
  assign reg_sel = reg_idx_t'(paddr[2]);
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cols_nxt = cols_r;
    rows_nxt = rows_r;
    if (cfg_wr) begin
      unique case (reg_sel)
        REG_COLS: cols_nxt = pwdata[CFG_W-1:0];
        REG_ROWS: rows_nxt = pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_COLS: prdata = DATA_W'(cols_r);
      REG_ROWS: prdata = DATA_W'(rows_r);
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= CFG_W'(1);
      rows_r <= CFG_W'(1);
    end else begin
      cols_r <= cols_nxt;
      rows_r <= rows_nxt;
    end
  end

  assign eff_cols = eff_dim(cols_r, DIM_SAT);
  assign eff_rows = eff_dim(rows_r, DIM_SAT);

  // front: accept, range check, divide
  gcni_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .eff_cols (eff_cols),
    .eff_rows (eff_rows),
    .job      (push_job),
    .job_push (job_push),
    .job_full (job_full)
  );

  // decoupling queue
  gcni_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .din   (push_job),
    .full  (job_full),
    .pop   (job_pop),
    .dout  (head_job),
    .valid (job_valid)
  );

  // back: neighbor selection and result register
  gcni_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .eff_cols  (eff_cols),
    .eff_rows  (eff_rows),
    .job       (head_job),
    .job_valid (job_valid),
    .job_pop   (job_pop),
    .out_ch    (out_ch)
  );

endmodule
